FILE: hw/rtl/ildl_pkg.sv
`default_nettype none
package ildl_pkg;

  localparam int Capacity  = 64;
  localparam int Width     = 32;
  localparam int PosW      = $clog2(Capacity);
  localparam int CntW      = $clog2(Capacity + 1);
  localparam int IdxW      = 7;
  localparam int CmpW      = (CntW > IdxW) ? CntW : IdxW;
  localparam int GroupSize = 8;
  localparam int NumGroups = (Capacity + GroupSize - 1) / GroupSize;

  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_READ     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_TRUNCATE = 3'd4,
    OP_CLEAR    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  index;
    logic [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [6:0]  count;
    logic [1:0]  status;
  } out_word_t;

  // Broadcast to every cell for one request.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic             load;
    logic             rd;
    logic [PosW-1:0]  pos;
    logic [Width-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/indexed_insert_delete_list.sv
// Flow: a word is accepted in S_IDLE, shifts or writes the cell chain in S_EXEC, and its result
// drains from the read tree in S_DRAIN, which waits while a held result is stalled; only S_IDLE takes a word.
// The cell chain moves every entry at once; the two-level read OR tree registers its group ORs.
// The result register lets the next word in while the last result still waits to be taken.
// Reset (rst_ni low, asynchronous) empties the list and drops any pending result;
// entry contents are not cleared.
`default_nettype none
module indexed_insert_delete_list (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire ildl_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output ildl_pkg::out_word_t       out_word_o
);

  ildl_pkg::state_e     state_q, state_d;
  ildl_pkg::cell_ctrl_t req_q, req_d;
  ildl_pkg::status_e    status_q, status_d;
  logic [ildl_pkg::CntW-1:0] count_q, count_d;
  logic                 out_valid_q, out_valid_d;
  ildl_pkg::out_word_t  out_q, out_d;

  logic in_accept, out_free, out_load, exec_en;
  logic [ildl_pkg::CmpW-1:0] idx_ext, cnt_ext, pos_sel;

  logic [ildl_pkg::Width-1:0] cell_data [ildl_pkg::Capacity];
  logic [ildl_pkg::Width-1:0] cell_left [ildl_pkg::Capacity];
  logic [ildl_pkg::Width-1:0] cell_right[ildl_pkg::Capacity];
  logic [ildl_pkg::Width-1:0] cell_rd   [ildl_pkg::Capacity];
  logic [ildl_pkg::Width-1:0] rd_sum;
  ildl_pkg::cell_ctrl_t       cell_ctrl;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign idx_ext   = ildl_pkg::CmpW'(in_word_i.index);
  assign cnt_ext   = ildl_pkg::CmpW'(count_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ildl_pkg::S_IDLE:  if (in_valid_i) state_d = ildl_pkg::S_EXEC;
      ildl_pkg::S_EXEC:  state_d = ildl_pkg::S_DRAIN;
      ildl_pkg::S_DRAIN: if (out_free) state_d = ildl_pkg::S_IDLE;
      default:           state_d = ildl_pkg::S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_stall_o = 1'b1;
    exec_en    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ildl_pkg::S_IDLE:  in_stall_o = 1'b0;
      ildl_pkg::S_EXEC:  exec_en    = 1'b1;
      ildl_pkg::S_DRAIN: out_load   = out_free;
      default:           in_stall_o = 1'b1;
    endcase
  end

  // Decode the request against the current count: clamp the position,
  // pick the status and the new count.
  always_comb begin
    req_d       = '0;
    req_d.value = in_word_i.value[ildl_pkg::Width-1:0];
    status_d    = ildl_pkg::ST_OK;
    count_d     = count_q;
    pos_sel     = idx_ext;
    unique case (in_word_i.op)
      ildl_pkg::OP_INSERT: begin
        if (count_q == ildl_pkg::CntW'(ildl_pkg::Capacity)) begin
          status_d = ildl_pkg::ST_FULL;
        end else begin
          if (idx_ext > cnt_ext) pos_sel = cnt_ext;
          req_d.shift_up = 1'b1;
          req_d.load     = 1'b1;
          count_d        = count_q + 1'b1;
        end
      end
      ildl_pkg::OP_DELETE, ildl_pkg::OP_READ, ildl_pkg::OP_WRITE: begin
        if (count_q == '0) begin
          status_d = ildl_pkg::ST_EMPTY;
        end else begin
          if (idx_ext >= cnt_ext) pos_sel = cnt_ext - 1'b1;
          req_d.shift_down = (in_word_i.op == ildl_pkg::OP_DELETE);
          req_d.rd         = (in_word_i.op == ildl_pkg::OP_READ);
          req_d.load       = (in_word_i.op == ildl_pkg::OP_WRITE);
          if (in_word_i.op == ildl_pkg::OP_DELETE) count_d = count_q - 1'b1;
        end
      end
      ildl_pkg::OP_TRUNCATE: begin
        if (idx_ext < cnt_ext) count_d = ildl_pkg::CntW'(idx_ext);
      end
      ildl_pkg::OP_CLEAR: count_d = '0;
      default: ;
    endcase
    req_d.pos = pos_sel[ildl_pkg::PosW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ildl_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_accept) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= req_d;
      status_q <= status_d;
    end
    if (out_load) out_q <= out_d;
  end

  // Hold the cells still outside the execute cycle. Keep the read select up:
  // a read moves nothing, and the tree must hold its word while the result waits.
  always_comb begin
    cell_ctrl = req_q;
    if (!exec_en) begin
      cell_ctrl.shift_up   = 1'b0;
      cell_ctrl.shift_down = 1'b0;
      cell_ctrl.load       = 1'b0;
    end
  end

  for (genvar i = 0; i < ildl_pkg::Capacity; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign cell_left[i] = '0;
    end else begin : g_left
      assign cell_left[i] = cell_data[i-1];
    end
    if (i == ildl_pkg::Capacity - 1) begin : g_last
      assign cell_right[i] = cell_data[i];
    end else begin : g_right
      assign cell_right[i] = cell_data[i+1];
    end

    ildl_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .cell_idx_i (ildl_pkg::PosW'(i)),
      .left_i     (cell_left[i]),
      .right_i    (cell_right[i]),
      .data_o     (cell_data[i]),
      .rd_o       (cell_rd[i])
    );
  end

  ildl_rdtree u_rdtree (
    .clk_i (clk_i),
    .rd_i  (cell_rd),
    .sum_o (rd_sum)
  );

  // Assemble the result word; the tree gives zero unless a read hit.
  always_comb begin
    out_d           = '0;
    out_d.read_data = 32'(rd_sum);
    out_d.count     = 7'(count_q);
    out_d.status    = status_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ildl_pkg::CntW'(ildl_pkg::Capacity))
    else $error("entry count above capacity");

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ildl_pkg::S_EXEC))
    else $error("accepted word did not enter execute");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == ildl_pkg::ST_FULL)
      |-> (out_word_o.count == 7'(ildl_pkg::Capacity)))
    else $error("full status with list not full");

  a_err_nodata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != ildl_pkg::ST_OK) |-> (out_word_o.read_data == '0))
    else $error("read data on failed request");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten while held");

endmodule
`default_nettype wire

FILE: hw/rtl/ildl_cell.sv
`default_nettype none
module ildl_cell (
  input  wire logic                       clk_i,
  input  wire ildl_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [ildl_pkg::PosW-1:0]  cell_idx_i,
  input  wire logic [ildl_pkg::Width-1:0] left_i,
  input  wire logic [ildl_pkg::Width-1:0] right_i,
  output logic      [ildl_pkg::Width-1:0] data_o,
  output logic      [ildl_pkg::Width-1:0] rd_o
);

  logic [ildl_pkg::Width-1:0] data_q, data_d;
  logic                       at_pos, past_pos;

  assign at_pos   = (cell_idx_i == ctrl_i.pos);
  assign past_pos = (cell_idx_i > ctrl_i.pos);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up && past_pos) begin
      data_d = left_i;
    end else if (ctrl_i.shift_down && (past_pos || at_pos)) begin
      data_d = right_i;
    end else if (ctrl_i.load && at_pos) begin
      data_d = ctrl_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  // Drive the word only from the addressed cell; the tree ORs all cells.
  assign rd_o   = (ctrl_i.rd && at_pos) ? data_q : '0;

endmodule
`default_nettype wire

FILE: hw/rtl/ildl_rdtree.sv
`default_nettype none
module ildl_rdtree (
  input  wire logic                       clk_i,
  input  wire logic [ildl_pkg::Width-1:0] rd_i [ildl_pkg::Capacity],
  output logic      [ildl_pkg::Width-1:0] sum_o
);

  localparam int PadN = ildl_pkg::NumGroups * ildl_pkg::GroupSize;

  logic [ildl_pkg::Width-1:0] pad     [PadN];
  logic [ildl_pkg::Width-1:0] group_d [ildl_pkg::NumGroups];
  logic [ildl_pkg::Width-1:0] group_q [ildl_pkg::NumGroups];

  for (genvar i = 0; i < PadN; i++) begin : g_pad
    if (i < ildl_pkg::Capacity) begin : g_real
      assign pad[i] = rd_i[i];
    end else begin : g_zero
      assign pad[i] = '0;
    end
  end

  for (genvar g = 0; g < ildl_pkg::NumGroups; g++) begin : g_grp
    always_comb begin
      group_d[g] = '0;
      for (int k = 0; k < ildl_pkg::GroupSize; k++) begin
        group_d[g] = group_d[g] | pad[g * ildl_pkg::GroupSize + k];
      end
    end

    always_ff @(posedge clk_i) begin
      group_q[g] <= group_d[g];
    end
  end

  always_comb begin
    sum_o = '0;
    for (int g = 0; g < ildl_pkg::NumGroups; g++) begin
      sum_o = sum_o | group_q[g];
    end
  end

endmodule
`default_nettype wire
